// File: sv/pctb_pkg.sv
package pctb_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF = 20;
  localparam int OUT_BITS       = 13;
  localparam int NUM_AXES       = 3;
  // 2.5 percent trim: cutoff = floor(count / 40)
  localparam int TRIM_DIV       = 40;
  localparam int REM_BITS       = $clog2(TRIM_DIV);

  typedef struct packed {
    logic bump;        // new point, raise the addressed bin
    logic scan;        // sweep read at the shared address
    logic clr;         // write zero at the shared address
    logic dir_high;    // sweep runs downward
    logic start_low;   // restart low scan state
    logic start_high;  // latch low bin, restart high scan state
  } lane_ctl_t;

endpackage

// File: sv/pctb_lane.sv
module pctb_lane #(
  parameter int COORD_BITS = pctb_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pctb_pkg::COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pctb_pkg::lane_ctl_t     ctl_i,
  input  logic [COORD_BITS-1:0]   bin_i,
  input  logic [COORD_BITS-1:0]   addr_i,
  input  logic [COUNT_BITS:0]     cutoff_i,
  output logic                    sat_o,
  output logic [COORD_BITS-1:0]   low_idx_o,
  output logic [COORD_BITS-1:0]   high_idx_o,
  output logic                    nonempty_o
);

  localparam int Depth   = 2 ** COORD_BITS;
  localparam int SumBits = COUNT_BITS + 2;

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rd_q;

  logic                  re, we;
  logic [COORD_BITS-1:0] ra, wa;
  logic [COUNT_BITS-1:0] wd;

  // increment pipeline
  logic                  b_vld_q;
  logic [COORD_BITS-1:0] b_idx_q;
  logic                  w_vld_q;
  logic [COORD_BITS-1:0] w_idx_q;
  logic [COUNT_BITS-1:0] w_dat_q;
  logic [COUNT_BITS-1:0] cur, inc;
  logic                  full;

  // scan state
  logic                  p_vld_q, p_high_q;
  logic [COORD_BITS-1:0] p_idx_q;
  logic [SumBits-1:0]    sum_q, sum_nx;
  logic                  found_q, any_q, hdone_q;
  logic [COORD_BITS-1:0] low_q, top_q, lowf_q, high_q;
  logic                  nz, geq;

  assign re = ctl_i.bump | ctl_i.scan;
  assign ra = ctl_i.bump ? bin_i : addr_i;

  // forward the previous write when back-to-back points hit the same bin
  assign cur  = (w_vld_q && (w_idx_q == b_idx_q)) ? w_dat_q : rd_q;
  assign full = &cur;
  assign inc  = full ? cur : cur + COUNT_BITS'(1);

  assign we = b_vld_q | ctl_i.clr;
  assign wa = b_vld_q ? b_idx_q : addr_i;
  assign wd = b_vld_q ? inc : '0;

  assign sat_o = b_vld_q & full;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      b_idx_q  <= '0;
      w_vld_q  <= 1'b0;
      w_idx_q  <= '0;
      w_dat_q  <= '0;
      p_vld_q  <= 1'b0;
      p_high_q <= 1'b0;
      p_idx_q  <= '0;
    end else begin
      b_vld_q  <= ctl_i.bump;
      b_idx_q  <= bin_i;
      w_vld_q  <= b_vld_q;
      w_idx_q  <= b_idx_q;
      w_dat_q  <= inc;
      p_vld_q  <= ctl_i.scan;
      p_high_q <= ctl_i.dir_high;
      p_idx_q  <= addr_i;
    end
  end

  assign nz     = |rd_q;
  assign geq    = sum_q >= SumBits'(cutoff_i);
  assign sum_nx = sum_q + SumBits'(rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
      hdone_q <= 1'b0;
      low_q   <= '0;
      top_q   <= '0;
      lowf_q  <= '0;
      high_q  <= '0;
    end else if (ctl_i.start_low) begin
      sum_q   <= '0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else if (ctl_i.start_high) begin
      sum_q   <= '0;
      hdone_q <= 1'b0;
      // no stop found: the low bin falls back to the top bin
      lowf_q  <= found_q ? low_q : top_q;
    end else if (p_vld_q && !p_high_q) begin
      if (nz) begin
        any_q <= 1'b1;
        top_q <= p_idx_q;
        if (!found_q) begin
          if (geq) begin
            found_q <= 1'b1;
            low_q   <= p_idx_q;
          end else begin
            sum_q <= sum_nx;
          end
        end
      end
    end else if (p_vld_q && p_high_q && !hdone_q) begin
      // the high scan never passes the low bin
      if (p_idx_q == lowf_q) begin
        high_q  <= p_idx_q;
        hdone_q <= 1'b1;
      end else if (nz) begin
        if (geq) begin
          high_q  <= p_idx_q;
          hdone_q <= 1'b1;
        end else begin
          sum_q <= sum_nx;
        end
      end
    end
  end

  assign low_idx_o  = lowf_q;
  assign high_idx_o = high_q;
  assign nonempty_o = any_q;

endmodule

// File: sv/pctb_merge.sv
module pctb_merge #(
  parameter int COORD_BITS = pctb_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pctb_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 count_i,
  input  logic [pctb_pkg::NUM_AXES-1:0]        sat_i,
  input  logic                                 push_i,
  input  logic [COORD_BITS-1:0]                low_idx_i  [pctb_pkg::NUM_AXES],
  input  logic [COORD_BITS-1:0]                high_idx_i [pctb_pkg::NUM_AXES],
  input  logic [pctb_pkg::NUM_AXES-1:0]        nonempty_i,
  input  logic                                 out_stall_i,
  output logic [COUNT_BITS:0]                  cutoff_o,
  output logic                                 out_free_o,
  output logic                                 out_valid_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] low_o  [pctb_pkg::NUM_AXES],
  output logic signed [pctb_pkg::OUT_BITS-1:0] high_o [pctb_pkg::NUM_AXES],
  output logic                                 overflow_o
);

  localparam int OutBits = pctb_pkg::OUT_BITS;
  localparam int Axes    = pctb_pkg::NUM_AXES;
  localparam int Bw      = (COORD_BITS + 3 > OutBits) ? COORD_BITS + 3 : OutBits;
  localparam logic [COORD_BITS-1:0] Half = COORD_BITS'(1) << (COORD_BITS - 1);

  logic [COUNT_BITS:0]                tot_q, tot_d;
  logic [COUNT_BITS:0]                cut_q, cut_d;
  logic [pctb_pkg::REM_BITS-1:0]      rem_q, rem_d;
  logic                               sat_q, sat_d;
  logic                               vld_q;
  logic signed [COORD_BITS-1:0]       lo_b [Axes];
  logic signed [COORD_BITS-1:0]       hi_b [Axes];
  logic signed [Bw-1:0]               lo_e [Axes];
  logic signed [Bw-1:0]               hi_e [Axes];
  logic signed [Bw-1:0]               lo_r [Axes];
  logic signed [Bw-1:0]               hi_r [Axes];
  logic signed [OutBits-1:0]          lo_q [Axes];
  logic signed [OutBits-1:0]          hi_q [Axes];
  logic                               ovf_q;

  // running count with a mod-40 remainder keeps floor(count/40) without a divider
  always_comb begin
    tot_d = tot_q;
    cut_d = cut_q;
    rem_d = rem_q;
    sat_d = sat_q | (|sat_i);
    if (push_i) begin
      tot_d = '0;
      cut_d = '0;
      rem_d = '0;
      sat_d = 1'b0;
    end else if (count_i) begin
      if (&tot_q) begin
        sat_d = 1'b1;
      end else begin
        tot_d = tot_q + (COUNT_BITS + 1)'(1);
        if (rem_q == pctb_pkg::REM_BITS'(pctb_pkg::TRIM_DIV - 1)) begin
          rem_d = '0;
          cut_d = cut_q + (COUNT_BITS + 1)'(1);
        end else begin
          rem_d = rem_q + pctb_pkg::REM_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      // bin index back to signed coordinate
      lo_b[a] = signed'(low_idx_i[a] ^ Half);
      hi_b[a] = signed'(high_idx_i[a] ^ Half);
      lo_e[a] = Bw'(lo_b[a]);
      hi_e[a] = Bw'(hi_b[a]);
      lo_r[a] = (lo_e[a] <<< 1) - hi_e[a];
      hi_r[a] = (hi_e[a] <<< 1) + hi_e[a] - (lo_e[a] <<< 1);
      if (!nonempty_i[a]) begin
        lo_r[a] = '0;
        hi_r[a] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      cut_q <= '0;
      rem_q <= '0;
      sat_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      tot_q <= tot_d;
      cut_q <= cut_d;
      rem_q <= rem_d;
      sat_q <= sat_d;
      vld_q <= push_i | (vld_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int a = 0; a < Axes; a++) begin
        lo_q[a] <= lo_r[a][OutBits-1:0];
        hi_q[a] <= hi_r[a][OutBits-1:0];
      end
      ovf_q <= sat_q;
    end
  end

  assign cutoff_o    = cut_q;
  assign out_free_o  = ~vld_q | ~out_stall_i;
  assign out_valid_o = vld_q;
  assign low_o       = lo_q;
  assign high_o      = hi_q;
  assign overflow_o  = ovf_q;

endmodule

// File: sv/point_cloud_trimmed_bounds.sv
// Trimmed bounding box of a 3-D point cloud. One point request is taken per
// cycle; each of the three axis lanes raises one bin of its own histogram
// memory (2^COORD_BITS bins) through a two-stage read-modify-write with
// forwarding. The point flagged last starts the bound computation: every lane
// sweeps its memory once upward (low cut) and once downward (high cut, which
// also clears the bins), one bin per cycle over its single read port; input
// stalls through both sweeps, and longer while the previous result still
// waits to be taken. The result sits in an output register, so points of the
// next set flow while it waits. After reset the block runs a clearing pass
// over all bins before taking points. Bin and point counts saturate;
// overflow_o reports it for the set.
module point_cloud_trimmed_bounds #(
  parameter int COORD_BITS = pctb_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pctb_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_BITS-1:0]         coord_x_i,
  input  logic signed [COORD_BITS-1:0]         coord_y_i,
  input  logic signed [COORD_BITS-1:0]         coord_z_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pctb_pkg::OUT_BITS-1:0] low_x_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] high_x_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] low_y_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] high_y_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] low_z_o,
  output logic signed [pctb_pkg::OUT_BITS-1:0] high_z_o,
  output logic                                 overflow_o
);

  localparam int Axes = pctb_pkg::NUM_AXES;
  localparam logic [COORD_BITS-1:0] Half = COORD_BITS'(1) << (COORD_BITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_LOW   = 3'd2;
  localparam logic [2:0] S_LWAIT = 3'd3;
  localparam logic [2:0] S_HIGH  = 3'd4;
  localparam logic [2:0] S_HWAIT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [COORD_BITS-1:0] cnt_q, cnt_d;
  logic                  in_acc, push, out_free;
  pctb_pkg::lane_ctl_t   ctl;

  logic [COORD_BITS-1:0]                coord    [Axes];
  logic [COORD_BITS-1:0]                bin      [Axes];
  logic [COORD_BITS-1:0]                low_idx  [Axes];
  logic [COORD_BITS-1:0]                high_idx [Axes];
  logic [Axes-1:0]                      nonempty;
  logic [Axes-1:0]                      sat;
  logic [COUNT_BITS:0]                  cutoff;
  logic signed [pctb_pkg::OUT_BITS-1:0] low_b  [Axes];
  logic signed [pctb_pkg::OUT_BITS-1:0] high_b [Axes];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign push       = (state_q == S_DONE) & out_free;

  assign ctl.bump       = in_acc;
  assign ctl.scan       = (state_q == S_LOW) | (state_q == S_HIGH);
  assign ctl.clr        = (state_q == S_HIGH) | (state_q == S_CLEAR);
  assign ctl.dir_high   = (state_q == S_HIGH);
  assign ctl.start_low  = (state_q == S_DRAIN);
  assign ctl.start_high = (state_q == S_HIGH) & (&cnt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last point's write land before sweeping
        cnt_d   = '0;
        state_d = S_LOW;
      end
      S_LOW: begin
        cnt_d = cnt_q + COORD_BITS'(1);
        if (&cnt_q) begin
          state_d = S_LWAIT;
        end
      end
      S_LWAIT: begin
        cnt_d   = '1;
        state_d = S_HIGH;
      end
      S_HIGH: begin
        cnt_d = cnt_q - COORD_BITS'(1);
        if (cnt_q == '0) begin
          state_d = S_HWAIT;
        end
      end
      S_HWAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cnt_d = cnt_q + COORD_BITS'(1);
        if (&cnt_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  for (genvar a = 0; a < Axes; a++) begin : g_lane
    assign bin[a] = coord[a] ^ Half;

    pctb_lane #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .bin_i      (bin[a]),
      .addr_i     (cnt_q),
      .cutoff_i   (cutoff),
      .sat_o      (sat[a]),
      .low_idx_o  (low_idx[a]),
      .high_idx_o (high_idx[a]),
      .nonempty_o (nonempty[a])
    );
  end

  pctb_merge #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (in_acc),
    .sat_i       (sat),
    .push_i      (push),
    .low_idx_i   (low_idx),
    .high_idx_i  (high_idx),
    .nonempty_i  (nonempty),
    .out_stall_i (out_stall_i),
    .cutoff_o    (cutoff),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .low_o       (low_b),
    .high_o      (high_b),
    .overflow_o  (overflow_o)
  );

  assign low_x_o  = low_b[0];
  assign high_x_o = high_b[0];
  assign low_y_o  = low_b[1];
  assign high_y_o = high_b[1];
  assign low_z_o  = low_b[2];
  assign high_z_o = high_b[2];

endmodule

// File: bench/point_cloud_trimmed_bounds_tb.sv
`timescale 1ns / 100ps

module point_cloud_trimmed_bounds_tb;

  localparam int CB        = pctb_pkg::COORD_BITS_DEF;
  localparam int NB        = pctb_pkg::COUNT_BITS_DEF;
  localparam int NUM_AXES  = pctb_pkg::NUM_AXES;
  localparam int OUT_BITS  = pctb_pkg::OUT_BITS;
  localparam int TRIM_DIV  = pctb_pkg::TRIM_DIV;
  localparam int NUM_BINS  = 1 << CB;
  localparam int CMIN      = -(1 << (CB - 1));
  localparam int CMAX      = (1 << (CB - 1)) - 1;
  localparam int unsigned BIN_MAX   = (1 << NB) - 1;
  localparam int unsigned TOTAL_MAX = (1 << (NB + 1)) - 1;
  localparam int NUM_BOUNDS    = 2 * NUM_AXES;
  // two sweeps per set plus pipeline slack
  localparam int SWEEP_CYCLES  = 2 * NUM_BINS + 16;
  localparam longint CYCLE_LIMIT = 6_000_000;
  localparam int RANDOM_POINTS   = 720;
  localparam int MIN_RANDOM_SETS = 30;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0] bound_t;
  typedef struct packed {
    logic                                ovf;
    logic [NUM_BOUNDS-1:0][OUT_BITS-1:0] bound;
  } box_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   last_i      = 1'b0;
  logic   out_stall_i = 1'b0;
  coord_t coord_x_i   = '0;
  coord_t coord_y_i   = '0;
  coord_t coord_z_i   = '0;
  logic   in_stall_o;
  logic   out_valid_o;
  bound_t low_x_o, high_x_o, low_y_o, high_y_o, low_z_o, high_z_o;
  logic   overflow_o;

  point_cloud_trimmed_bounds dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .low_x_o     (low_x_o),
    .high_x_o    (high_x_o),
    .low_y_o     (low_y_o),
    .high_y_o    (high_y_o),
    .low_z_o     (low_z_o),
    .high_z_o    (high_z_o),
    .overflow_o  (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: one histogram per axis, point count, saturation flag
  int unsigned axis_hist [NUM_AXES][NUM_BINS];
  int unsigned set_points    = 0;
  bit          set_saturated = 1'b0;
  box_t        expected_boxes[$];

  int     mismatch_count = 0;
  int     points_sent    = 0;
  int     sets_closed    = 0;
  int     boxes_checked  = 0;
  int     burst_left     = 0;
  int     stall_left     = 0;
  longint cycle_count    = 0;

  function automatic int bin_of(coord_t c);
    return int'({~c[CB-1], c[CB-2:0]});
  endfunction

  function automatic void tally_point(coord_t cx, coord_t cy, coord_t cz);
    int idx [NUM_AXES];
    idx[0] = bin_of(cx);
    idx[1] = bin_of(cy);
    idx[2] = bin_of(cz);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (axis_hist[a][idx[a]] >= BIN_MAX) begin
        axis_hist[a][idx[a]] = BIN_MAX;
        set_saturated = 1'b1;
      end else begin
        axis_hist[a][idx[a]]++;
      end
    end
    if (set_points >= TOTAL_MAX) begin
      set_points = TOTAL_MAX;
      set_saturated = 1'b1;
    end else begin
      set_points++;
    end
  endfunction

  function automatic void trim_axis(int a, int unsigned cutoff,
                                    output bound_t lo, output bound_t hi);
    int first, top, lo_bin, hi_bin, low_edge, high_edge;
    longint unsigned sum;
    first = -1;
    top = -1;
    for (int i = 0; i < NUM_BINS; i++) begin
      if (axis_hist[a][i] != 0) begin
        if (first < 0) first = i;
        top = i;
      end
    end
    if (first < 0) begin
      lo = '0;
      hi = '0;
      return;
    end
    // low cut: stop at the first non-empty bin reached with the cutoff met
    sum = 0;
    lo_bin = -1;
    for (int i = first; i <= top; i++) begin
      if (axis_hist[a][i] != 0) begin
        if (sum >= cutoff) begin
          lo_bin = i;
          break;
        end
        sum += axis_hist[a][i];
      end
    end
    if (lo_bin < 0) lo_bin = top;
    // high cut: walk down over non-empty bins, never below the low bin
    sum = 0;
    hi_bin = top;
    while (hi_bin > lo_bin && sum < cutoff) begin
      sum += axis_hist[a][hi_bin];
      hi_bin--;
      while (hi_bin > lo_bin && axis_hist[a][hi_bin] == 0) hi_bin--;
    end
    low_edge = lo_bin - NUM_BINS / 2;
    high_edge = hi_bin - NUM_BINS / 2;
    lo = bound_t'(2 * low_edge - high_edge);
    hi = bound_t'(3 * high_edge - 2 * low_edge);
  endfunction

  function automatic void close_set();
    box_t box;
    bound_t lo, hi;
    int unsigned cutoff;
    cutoff = set_points / TRIM_DIV;
    for (int a = 0; a < NUM_AXES; a++) begin
      trim_axis(a, cutoff, lo, hi);
      box.bound[2*a] = lo;
      box.bound[2*a+1] = hi;
    end
    box.ovf = set_saturated;
    expected_boxes.push_back(box);
    for (int a = 0; a < NUM_AXES; a++)
      for (int i = 0; i < NUM_BINS; i++) axis_hist[a][i] = 0;
    set_points = 0;
    set_saturated = 1'b0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
             $time, boxes_checked, what, got, want);
  endtask

  // one point request; idle gaps fall between bursts
  task automatic send_point(coord_t cx, coord_t cy, coord_t cz, logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    coord_x_i <= cx;
    coord_y_i <= cy;
    coord_z_i <= cz;
    last_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    tally_point(cx, cy, cz);
    points_sent++;
    if (is_last) begin
      close_set();
      sets_closed++;
    end
  endtask

  function automatic coord_t pick_coord(int center, int spread);
    int v;
    case ($urandom_range(0, 15))
      0: v = CMIN;
      1: v = CMAX;
      2: v = int'($urandom_range(0, NUM_BINS - 1)) - NUM_BINS / 2;
      default: v = center + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return coord_t'(v);
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 25;
      default: return 300;
    endcase
  endfunction

  task automatic test_single_points();
    send_point(coord_t'(CMIN), coord_t'(CMAX), coord_t'(0), 1'b1);
    send_point(coord_t'(CMAX), coord_t'(CMIN), coord_t'(-1), 1'b1);
    send_point(coord_t'(-1), coord_t'(0), coord_t'(1), 1'b1);
    send_point(coord_t'(0), coord_t'(-1), coord_t'(CMIN), 1'b1);
  endtask

  // wide empty stretches between the occupied bins
  task automatic test_sparse_set();
    send_point(coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), 1'b0);
    send_point(coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN), 1'b0);
    send_point(coord_t'(0), coord_t'(-100), coord_t'(37), 1'b0);
    send_point(coord_t'(-100), coord_t'(37), coord_t'(0), 1'b0);
    send_point(coord_t'(37), coord_t'(0), coord_t'(-100), 1'b1);
  endtask

  task automatic test_repeated_bin();
    for (int k = 1; k <= 4; k++)
      send_point(coord_t'(5), coord_t'(-5), coord_t'(CMAX), k == 4);
  endtask

  // single-point sets back to back, results pile up behind receiver stalls
  task automatic test_back_to_back();
    for (int k = 0; k < 6; k++)
      send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
  endtask

  task automatic test_random_sets();
    int points_done, sets_done, set_len, sel;
    int cx, cy, cz, sx, sy, sz;
    points_done = 0;
    sets_done = 0;
    while (points_done < RANDOM_POINTS || sets_done < MIN_RANDOM_SETS) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) set_len = $urandom_range(1, 12);
      else if (sel < 17) set_len = $urandom_range(13, 39);
      else set_len = $urandom_range(40, 90);
      cx = int'($urandom_range(0, NUM_BINS - 1)) - NUM_BINS / 2;
      cy = int'($urandom_range(0, NUM_BINS - 1)) - NUM_BINS / 2;
      cz = int'($urandom_range(0, NUM_BINS - 1)) - NUM_BINS / 2;
      sx = pick_spread();
      sy = pick_spread();
      sz = pick_spread();
      for (int k = 1; k <= set_len; k++)
        send_point(pick_coord(cx, sx), pick_coord(cy, sy), pick_coord(cz, sz),
                   k == set_len);
      points_done += set_len;
      sets_done++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    box_t seen, want;
    string names [NUM_BOUNDS];
    names = '{"low_x", "high_x", "low_y", "high_y", "low_z", "high_z"};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.bound = {high_z_o, low_z_o, high_y_o, low_y_o, high_x_o, low_x_o};
      seen.ovf = overflow_o;
      if (expected_boxes.size() == 0) begin
        report_mismatch("result with no set pending", $signed(seen.bound[0]), 0);
      end else begin
        want = expected_boxes.pop_front();
        for (int f = 0; f < NUM_BOUNDS; f++)
          if (seen.bound[f] !== want.bound[f])
            report_mismatch(names[f], $signed(seen.bound[f]), $signed(want.bound[f]));
        if (seen.ovf !== want.ovf)
          report_mismatch("overflow", seen.ovf, want.ovf);
      end
      boxes_checked++;
    end
  end

  // receiver: free runs, short stalls, and now and then a long hold
  always @(posedge clk_i) begin : sink_pattern
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 60);
      end else if (pick < 19) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 8);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(100, 2500);
      end
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("point_cloud_trimmed_bounds_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_points();
    test_sparse_set();
    test_repeated_bin();
    test_back_to_back();
    test_random_sets();
    in_valid_i <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    // catch any stray result after the last set
    repeat (SWEEP_CYCLES) @(posedge clk_i);
    $display("sent %0d points in %0d sets, checked %0d bounding boxes",
             points_sent, sets_closed, boxes_checked);
    $display("covered edge bins, sparse and repeated bins, trimmed sets, output stalls");
    if (mismatch_count == 0) begin
      $display("point_cloud_trimmed_bounds_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("point_cloud_trimmed_bounds_tb failed");
    end
    $finish;
  end

endmodule
